// ===== design/ole_pkg.sv =====
// Ordered list engine: shared types, operation and status codes, defaults.
// No dependencies; used by ole_ctrl and the top level.

package ole_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;

    localparam logic [3:0] MODE_INS_HEAD   = 4'd0;
    localparam logic [3:0] MODE_INS_TAIL   = 4'd1;
    localparam logic [3:0] MODE_DEL_HEAD   = 4'd2;
    localparam logic [3:0] MODE_DEL_TAIL   = 4'd3;
    localparam logic [3:0] MODE_INS_AFTER  = 4'd4;
    localparam logic [3:0] MODE_INS_BEFORE = 4'd5;
    localparam logic [3:0] MODE_DEL_AFTER  = 4'd6;
    localparam logic [3:0] MODE_DEL_BEFORE = 4'd7;
    localparam logic [3:0] MODE_SEARCH     = 4'd8;
    localparam logic [3:0] MODE_READ       = 4'd9;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHORT = 2'd1;
    localparam logic [1:0] STAT_NOKEY = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]        mode;
        logic signed [31:0] key;
        logic signed [31:0] new_value;
        logic [7:0]        position_req;
    } ole_req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] data_out;
        logic [3:0]        found_at;
        logic [4:0]        length;
    } ole_rsp_t;

endpackage

// ===== design/ole_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/ole_ctrl.sv =====
// Ordered list engine sequencer: key scan, entry shifting and count keeping
// over the entry RAM. Depends on ole_pkg.

module ole_ctrl #(
    parameter int CAPACITY = ole_pkg::DEF_CAPACITY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  ole_pkg::ole_req_t           req_data,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ole_pkg::ole_rsp_t           res_data,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [ole_pkg::DATA_W-1:0]  wr_data,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [ole_pkg::DATA_W-1:0]  rd_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_PLAN, S_SHIFT, S_PUT, S_RDIDX, S_CAPT, S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [3:0]                 mode_reg, mode_next;
    logic [31:0]                key_reg, key_next;
    logic [31:0]                nv_reg, nv_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           tgt_reg, tgt_next;
    logic [CNT_W-1:0]           scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]           scan_hi_reg, scan_hi_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]           cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]           sh_rd_reg, sh_rd_next;
    logic [IDX_W-1:0]           sh_last_reg, sh_last_next;
    logic                       issue_reg, issue_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]           pend_wr_reg, pend_wr_next;
    logic [1:0]                 status_reg, status_next;
    logic [31:0]                data_reg, data_next;
    logic [CNT_W-1:0]           pos_reg, pos_next;

    logic                       is_ins;
    logic [CNT_W-1:0]           req_pos;
    logic [31:0]                pos_ext;
    logic [31:0]                cnt_ext;

    assign is_ins = (mode_reg inside {ole_pkg::MODE_INS_HEAD, ole_pkg::MODE_INS_TAIL,
                                      ole_pkg::MODE_INS_AFTER, ole_pkg::MODE_INS_BEFORE});

    // read index clamps to the tail
    assign req_pos = (32'(req_data.position_req) < 32'(count_reg))
                     ? CNT_W'(req_data.position_req) : count_reg - ONE_C;

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign pos_ext = 32'(pos_reg);
    assign cnt_ext = 32'(count_reg);
    assign res_data.status   = status_reg;
    assign res_data.data_out = data_reg;
    assign res_data.found_at = pos_ext[3:0];
    assign res_data.length   = cnt_ext[4:0];

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        nv_next         = nv_reg;
        count_next      = count_reg;
        tgt_next        = tgt_reg;
        scan_idx_next   = scan_idx_reg;
        scan_hi_next    = scan_hi_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        sh_rd_next      = sh_rd_reg;
        sh_last_next    = sh_last_reg;
        issue_next      = issue_reg;
        pend_valid_next = pend_valid_reg;
        pend_wr_next    = pend_wr_reg;
        status_next     = status_reg;
        data_next       = data_reg;
        pos_next        = pos_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next     = req_data.mode;
                    key_next      = req_data.key;
                    nv_next       = req_data.new_value;
                    status_next   = ole_pkg::STAT_OK;
                    data_next     = '0;
                    pos_next      = '0;
                    scan_idx_next = '0;
                    scan_hi_next  = count_reg;
                    state_next    = S_DONE;
                    case (req_data.mode)
                        ole_pkg::MODE_INS_HEAD, ole_pkg::MODE_INS_TAIL:
                        begin
                            if (count_reg == CAP_C)
                                status_next = ole_pkg::STAT_FULL;
                            else
                            begin
                                tgt_next = (req_data.mode == ole_pkg::MODE_INS_HEAD)
                                           ? '0 : count_reg;
                                state_next = S_PLAN;
                            end
                        end
                        ole_pkg::MODE_DEL_HEAD, ole_pkg::MODE_DEL_TAIL:
                        begin
                            if (count_reg == '0)
                                status_next = ole_pkg::STAT_SHORT;
                            else
                            begin
                                tgt_next = (req_data.mode == ole_pkg::MODE_DEL_HEAD)
                                           ? '0 : count_reg - ONE_C;
                                state_next = S_PLAN;
                            end
                        end
                        ole_pkg::MODE_INS_AFTER, ole_pkg::MODE_INS_BEFORE:
                        begin
                            if (count_reg == '0)
                                status_next = ole_pkg::STAT_SHORT;
                            else if (count_reg == CAP_C)
                                status_next = ole_pkg::STAT_FULL;
                            else
                                state_next = S_SCAN;
                        end
                        ole_pkg::MODE_DEL_AFTER:
                        begin
                            if (count_reg < TWO_C)
                                status_next = ole_pkg::STAT_SHORT;
                            else
                            begin
                                scan_hi_next = count_reg - ONE_C;
                                state_next   = S_SCAN;
                            end
                        end
                        ole_pkg::MODE_DEL_BEFORE:
                        begin
                            if (count_reg < TWO_C)
                                status_next = ole_pkg::STAT_SHORT;
                            else
                            begin
                                scan_idx_next = ONE_C;
                                state_next    = S_SCAN;
                            end
                        end
                        ole_pkg::MODE_SEARCH:
                        begin
                            if (count_reg == '0)
                                status_next = ole_pkg::STAT_SHORT;
                            else
                                state_next = S_SCAN;
                        end
                        ole_pkg::MODE_READ:
                        begin
                            if (count_reg == '0)
                                status_next = ole_pkg::STAT_SHORT;
                            else
                            begin
                                tgt_next   = req_pos;
                                state_next = S_RDIDX;
                            end
                        end
                        default:
                        begin
                            status_next = ole_pkg::STAT_OK;
                        end
                    endcase
                end
            end

            // reads issue one per cycle; compare lags the read by one
            S_SCAN:
            begin
                if (cmp_valid_reg && rd_data == key_reg)
                begin
                    case (mode_reg)
                        ole_pkg::MODE_SEARCH:
                        begin
                            data_next  = rd_data;
                            pos_next   = cmp_idx_reg;
                            state_next = S_DONE;
                        end
                        ole_pkg::MODE_INS_BEFORE:
                        begin
                            tgt_next   = cmp_idx_reg;
                            state_next = S_PLAN;
                        end
                        ole_pkg::MODE_DEL_BEFORE:
                        begin
                            tgt_next   = cmp_idx_reg - ONE_C;
                            state_next = S_PLAN;
                        end
                        default:
                        begin
                            tgt_next   = cmp_idx_reg + ONE_C;
                            state_next = S_PLAN;
                        end
                    endcase
                end
                else if (scan_idx_reg < scan_hi_reg)
                begin
                    rd_addr        = scan_idx_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                    scan_idx_next  = scan_idx_reg + ONE_C;
                end
                else
                begin
                    status_next = ole_pkg::STAT_NOKEY;
                    state_next  = S_DONE;
                end
            end

            S_PLAN:
            begin
                pend_valid_next = 1'b0;
                if (is_ins)
                begin
                    if (tgt_reg == count_reg)
                        state_next = S_PUT;
                    else
                    begin
                        sh_rd_next   = IDX_W'(count_reg - ONE_C);
                        sh_last_next = tgt_reg[IDX_W-1:0];
                        issue_next   = 1'b1;
                        state_next   = S_SHIFT;
                    end
                end
                else
                begin
                    if (tgt_reg == count_reg - ONE_C)
                    begin
                        count_next = count_reg - ONE_C;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        sh_rd_next   = IDX_W'(tgt_reg + ONE_C);
                        sh_last_next = IDX_W'(count_reg - ONE_C);
                        issue_next   = 1'b1;
                        state_next   = S_SHIFT;
                    end
                end
            end

            // read one entry, write it one slot over in the next cycle
            S_SHIFT:
            begin
                wr_en   = pend_valid_reg;
                wr_addr = pend_wr_reg;
                wr_data = rd_data;
                if (issue_reg)
                begin
                    rd_addr         = sh_rd_reg;
                    pend_valid_next = 1'b1;
                    pend_wr_next    = is_ins ? sh_rd_reg + 1'b1 : sh_rd_reg - 1'b1;
                    if (sh_rd_reg == sh_last_reg)
                        issue_next = 1'b0;
                    else
                        sh_rd_next = is_ins ? sh_rd_reg - 1'b1 : sh_rd_reg + 1'b1;
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (is_ins)
                        state_next = S_PUT;
                    else
                    begin
                        count_next = count_reg - ONE_C;
                        state_next = S_DONE;
                    end
                end
            end

            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = tgt_reg[IDX_W-1:0];
                wr_data    = nv_reg;
                count_next = count_reg + ONE_C;
                state_next = S_DONE;
            end

            S_RDIDX:
            begin
                rd_addr    = tgt_reg[IDX_W-1:0];
                state_next = S_CAPT;
            end

            S_CAPT:
            begin
                data_next  = rd_data;
                pos_next   = tgt_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= '0;
            key_reg        <= '0;
            nv_reg         <= '0;
            count_reg      <= '0;
            tgt_reg        <= '0;
            scan_idx_reg   <= '0;
            scan_hi_reg    <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            sh_rd_reg      <= '0;
            sh_last_reg    <= '0;
            issue_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_wr_reg    <= '0;
            status_reg     <= ole_pkg::STAT_OK;
            data_reg       <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            key_reg        <= key_next;
            nv_reg         <= nv_next;
            count_reg      <= count_next;
            tgt_reg        <= tgt_next;
            scan_idx_reg   <= scan_idx_next;
            scan_hi_reg    <= scan_hi_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_idx_reg    <= cmp_idx_next;
            sh_rd_reg      <= sh_rd_next;
            sh_last_reg    <= sh_last_next;
            issue_reg      <= issue_next;
            pend_valid_reg <= pend_valid_next;
            pend_wr_reg    <= pend_wr_next;
            status_reg     <= status_next;
            data_reg       <= data_next;
            pos_reg        <= pos_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != S_IDLE))
        else $error("accepted transfer did not start work");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) ||
                  count_reg == $past(count_reg) + ONE_C ||
                  count_reg == $past(count_reg) - ONE_C))
        else $error("entry count moved by more than one");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < CAPACITY && 32'(wr_addr) <= 32'(count_reg)))
        else $error("RAM write outside the list");

    a_shift_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && !issue_reg) |-> pend_valid_reg)
        else $error("shift finished without its last write");

endmodule

// ===== design/ordered_list_engine_top.sv =====
// Ordered list engine top level: sequencer, entry RAM and output register.
// Depends on ole_pkg, ole_ram and ole_ctrl.
//
// Keeps an ordered list of up to CAPACITY signed 32-bit entries (head at
// position 0) and its count. One request transfer on req (valid/stall)
// carries a mode, key, new value and read index; each request yields
// exactly one response transfer on rsp with status, data, position and the
// count after the request. Requests are handled one at a time.
// Work per mode:
//   failed precheck or unused mode: no RAM access; read by index: one read;
//   head/tail insert or delete: one entry shifted per cycle;
//   search: one entry compared per cycle;
//   keyed insert/delete: scan up to the match, then shift the entries past
//   it. One RAM read and one write per cycle set both walks.
// A new request is taken the cycle after a result moves into the output
// register, so one response may wait on rsp_stall while the next request
// runs; further requests then stall until the response is taken.
// Reset empties the list at once; no clearing pass is needed.

module ordered_list_engine_top #(
    parameter int CAPACITY = ole_pkg::DEF_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ole_pkg::ole_req_t req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ole_pkg::ole_rsp_t rsp_data
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic                       res_valid;
    logic                       res_ready;
    ole_pkg::ole_rsp_t          res_data;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic [ole_pkg::DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]           rd_addr;
    logic [ole_pkg::DATA_W-1:0] rd_data;

    logic                       out_valid_reg;
    ole_pkg::ole_rsp_t          out_data_reg;

    ole_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ole_ram #(
        .WIDTH (ole_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !out_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
            if (res_valid)
                out_data_reg <= res_data;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule
